/* design/lttb_pkg.sv */
// ----------------------------------------------------------------------------
// lttb_pkg
// Shared types and constants of the largest-triangle-three-buckets downsampler.
// ----------------------------------------------------------------------------
`default_nettype none

package lttb_pkg;

  // storage and field widths
  localparam int MaxSamples = 2048;
  localparam int AddrW      = $clog2(MaxSamples);
  localparam int CntW       = AddrW + 1;
  localparam int SampleW    = 16;
  localparam int CfgW       = 12;
  localparam int BndW       = CntW + 1;
  localparam int DivNW      = 2 * AddrW;
  localparam int DivDW      = AddrW;
  localparam int VsumW      = SampleW + CntW;
  localparam int IsumW      = AddrW + CntW;
  localparam int PcW        = AddrW + CntW;
  localparam int DxW        = PcW + 2;
  localparam int DyW        = VsumW + 1;
  localparam int PaW        = DxW + SampleW + 1;
  localparam int PbW        = CntW + DyW;
  localparam int AreaW      = PaW + 2;

  // configuration register indexes
  localparam logic RegSampleCount  = 1'b0;
  localparam logic RegTargetPoints = 1'b1;

  localparam logic [CfgW-1:0] SampleCountRst  = CfgW'(2048);
  localparam logic [CfgW-1:0] TargetPointsRst = CfgW'(256);

  typedef enum logic [3:0] {
    S_IDLE,
    S_PLAN,
    S_DIVGO,
    S_DIVWAIT,
    S_ACC,
    S_SELPREP,
    S_SELDXDY,
    S_SCAN,
    S_LOAD,
    S_LDWAIT,
    S_EMIT
  } state_e;

endpackage

`default_nettype wire

/* design/lttb_if.sv */
// ----------------------------------------------------------------------------
// lttb_sample_if / lttb_result_if
// Valid/ready channels for input samples and kept indices.
// ----------------------------------------------------------------------------
`default_nettype none

interface lttb_sample_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample_value;

  modport source (output valid, output sample_value, input ready);
  modport sink (input valid, input sample_value, output ready);
endinterface

interface lttb_result_if;
  logic        valid;
  logic        ready;
  logic [10:0] kept_index;
  logic        run_last;
  logic        selection_done;

  modport source (output valid, output kept_index, output run_last, output selection_done,
                  input ready);
  modport sink (input valid, input kept_index, input run_last, input selection_done,
                output ready);
endinterface

`default_nettype wire

/* design/lttb_downsampler_top.sv */
// ----------------------------------------------------------------------------
// lttb_downsampler_top
// Largest-triangle-three-buckets downsampling: stores samples of one run and
// sends out the indices of the kept samples.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake      | payload
//  ----------+-----+----------------+-------------------------------------------
//  in_if     | in  | valid/ready    | sample_value
//  out_if    | out | valid/ready    | kept_index, run_last, selection_done
//  cfg       | in  | cfg_we_i       | cfg_index_i, cfg_data_i
//
//  A sample passes the transfer, plan and emit states, emitting its results in
//  turn, and the accumulate state while a middle bucket is open. Closing a
//  bucket adds the setup states, a scan of the sample memory, one read port,
//  one sample per cycle, and the load of the kept sample; three bound divisions
//  run on the first middle sample after a run starts or a bucket closes. No
//  clearing pass after reset. A stalled output holds the item in the emit
//  state; one result waits in the output register while the next item is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module lttb_downsampler_top (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         cfg_we_i,
  input  wire                         cfg_index_i,
  input  wire  [lttb_pkg::CfgW-1:0]   cfg_data_i,
  lttb_sample_if.sink                 in_if,
  lttb_result_if.source               out_if
);
  import lttb_pkg::*;

  state_e state_q, state_d;

  // configuration
  logic [CfgW-1:0] sample_count_q, target_points_q;
  logic [CntW-1:0] n_c, n_m1;
  logic [CntW-1:0] t_v;
  logic [CntW-1:0] m_v;

  // run state
  logic [CntW-1:0]            counter_q;
  logic [AddrW-1:0]           bucket_q;
  logic [AddrW-1:0]           prev_idx_q;
  logic signed [SampleW-1:0]  prev_val_q;
  logic signed [VsumW-1:0]    vsum_q;
  logic [IsumW-1:0]           isum_q;
  logic [CntW-1:0]            cnt_q;

  // current item
  logic [AddrW-1:0]           item_i_q;
  logic                       item_last_q;
  logic signed [SampleW-1:0]  item_v_q;

  // bucket bound cache
  logic [BndW-1:0] bnd_q [3];
  logic            bnd_valid_q;
  logic [1:0]      bi_q;

  // result slots
  logic [AddrW-1:0] res_idx_q [2];
  logic             res_done_q [2];
  logic [1:0]       res_cnt_q;
  logic [1:0]       res_ptr_q;

  // output register
  logic             out_valid_q;
  logic [AddrW-1:0] out_idx_q;
  logic             out_last_q, out_done_q;

  // memory
  logic signed [SampleW-1:0] mem [MaxSamples];
  logic signed [SampleW-1:0] rdata_q;
  logic                      rd_en;
  logic [AddrW-1:0]          raddr;

  // scan pipeline
  logic [CntW-1:0]           j_q;
  logic                      s1_v_q, s2_v_q;
  logic [AddrW-1:0]          s1_j_q, s2_j_q;
  logic signed [PaW-1:0]     pa_q;
  logic signed [PbW-1:0]     pb_q;
  logic signed [AreaW-1:0]   best_area_q;
  logic [AddrW-1:0]          best_q;
  logic [BndW-1:0]           be_q;
  logic [PcW-1:0]            pc_q;
  logic signed [DyW-1:0]     ypc_q;
  logic signed [DxW-1:0]     dx_q;
  logic signed [DyW-1:0]     dy_q;

  // divider
  logic              div_start;
  logic              div_done;
  logic [DivNW-1:0]  div_q;
  logic [AddrW-1:0]  div_k;
  logic [DivNW-1:0]  div_n;

  logic in_xfer, out_free, out_load, issue, sel_now, acc_hit;
  logic [CntW-1:0] acc_cnt_inc;
  logic [CntW-1:0] i_cur;
  logic            last_cur;
  logic [BndW-1:0] hi_v, be_v;
  logic signed [SampleW:0]   dv;
  logic signed [CntW-1:0]    pj;
  logic signed [PaW-1:0]     pa_d;
  logic signed [PbW-1:0]     pb_d;
  logic signed [AreaW-1:0]   area, area_abs;

  // clamped run length; target and middle bucket count
  always_comb begin
    if (sample_count_q == '0) n_c = CntW'(1);
    else if (sample_count_q > CfgW'(MaxSamples)) n_c = CntW'(MaxSamples);
    else n_c = CntW'(sample_count_q);
  end
  assign n_m1 = n_c - 1'b1;
  assign t_v  = CntW'(target_points_q);
  assign m_v  = t_v - CntW'(2);

  assign in_xfer  = in_if.valid && (state_q == S_IDLE);
  assign last_cur = counter_q >= n_m1;
  assign i_cur    = last_cur ? n_m1 : counter_q;

  // bounds for accumulation and selection
  assign hi_v  = (bnd_q[2] > BndW'(n_c)) ? BndW'(n_c) : bnd_q[2];
  assign be_v  = (bnd_q[1] > BndW'(n_m1)) ? BndW'(n_m1) : bnd_q[1];
  assign acc_hit = BndW'(item_i_q) >= bnd_q[1];
  assign sel_now = (BndW'(item_i_q) + 1'b1 >= hi_v) || item_last_q;
  assign acc_cnt_inc = cnt_q + 1'b1;

  // divider operands
  assign div_k = bucket_q + AddrW'(bi_q);
  assign div_n = div_k * AddrW'(n_c - CntW'(2));

  lttb_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_n),
    .divisor_i  (m_v[AddrW-1:0]),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  // output handshake
  assign out_free = !out_valid_q || out_if.ready;
  assign out_load = (state_q == S_EMIT) && (res_ptr_q != res_cnt_q) && out_free;

  assign issue = (state_q == S_SCAN) && (BndW'(j_q) < be_q);
  assign rd_en = issue || (state_q == S_LOAD);
  assign raddr = (state_q == S_SCAN) ? j_q[AddrW-1:0] : best_q;

  // scan arithmetic
  assign dv   = (SampleW+1)'(rdata_q) - (SampleW+1)'(prev_val_q);
  assign pj   = $signed({1'b0, prev_idx_q}) - $signed({1'b0, s1_j_q});
  assign pa_d = PaW'(dx_q) * PaW'(dv);
  assign pb_d = PbW'(pj) * PbW'(dy_q);
  assign area = AreaW'(pa_q) - AreaW'(pb_q);
  assign area_abs = area[AreaW-1] ? -area : area;

  // next state
  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    case (state_q)
      S_IDLE: if (in_if.valid) state_d = S_PLAN;
      S_PLAN: begin
        if (t_v >= n_c || t_v < CntW'(2) || item_i_q == '0) state_d = S_EMIT;
        else if (CntW'(bucket_q) < m_v) state_d = bnd_valid_q ? S_ACC : S_DIVGO;
        else state_d = S_EMIT;
      end
      S_DIVGO: begin
        div_start = 1'b1;
        state_d   = S_DIVWAIT;
      end
      S_DIVWAIT: if (div_done) state_d = (bi_q == 2'd2) ? S_ACC : S_DIVGO;
      S_ACC: state_d = sel_now ? S_SELPREP : S_EMIT;
      S_SELPREP: state_d = S_SELDXDY;
      S_SELDXDY: state_d = S_SCAN;
      S_SCAN: if (!issue && !s1_v_q && !s2_v_q) state_d = S_LOAD;
      S_LOAD: state_d = S_LDWAIT;
      S_LDWAIT: state_d = S_EMIT;
      S_EMIT: if (res_ptr_q == res_cnt_q) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_count_q  <= SampleCountRst;
      target_points_q <= TargetPointsRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegSampleCount:  sample_count_q  <= cfg_data_i;
        RegTargetPoints: target_points_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sample memory
  always_ff @(posedge clk_i) begin
    if (in_xfer) mem[i_cur[AddrW-1:0]] <= in_if.sample_value;
    if (rd_en) rdata_q <= mem[raddr];
  end

  // run and control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      counter_q   <= '0;
      bucket_q    <= '0;
      prev_idx_q  <= '0;
      prev_val_q  <= '0;
      vsum_q      <= '0;
      isum_q      <= '0;
      cnt_q       <= '0;
      bnd_valid_q <= 1'b0;
      bi_q        <= '0;
      res_cnt_q   <= '0;
      res_ptr_q   <= '0;
      out_valid_q <= 1'b0;
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      item_last_q <= 1'b0;
    end else begin
      if (cfg_we_i) bnd_valid_q <= 1'b0;
      // item transfer
      if (in_xfer) begin
        item_last_q <= last_cur;
        counter_q   <= last_cur ? '0 : i_cur + 1'b1;
      end
      // result planning
      if (state_q == S_PLAN) begin
        res_ptr_q <= '0;
        bi_q      <= '0;
        if (t_v >= n_c) begin
          res_cnt_q <= 2'd1;
        end else if (t_v < CntW'(2)) begin
          if (item_i_q == '0 && item_last_q) res_cnt_q <= 2'd2;
          else if (item_i_q == '0 || item_last_q) res_cnt_q <= 2'd1;
          else res_cnt_q <= 2'd0;
        end else if (item_i_q == '0) begin
          res_cnt_q  <= 2'd1;
          prev_idx_q <= '0;
          prev_val_q <= item_v_q;
        end else if (CntW'(bucket_q) < m_v) begin
          res_cnt_q <= 2'd0;
        end else begin
          res_cnt_q <= item_last_q ? 2'd1 : 2'd0;
        end
      end
      // bound divisions
      if (state_q == S_DIVWAIT && div_done) begin
        if (bi_q == 2'd2) bnd_valid_q <= 1'b1;
        else bi_q <= bi_q + 1'b1;
      end
      // next bucket sums
      if (state_q == S_ACC && acc_hit) begin
        vsum_q <= vsum_q + VsumW'(item_v_q);
        isum_q <= isum_q + IsumW'(item_i_q);
        cnt_q  <= acc_cnt_inc;
      end
      // scan pipeline valids
      s1_v_q <= issue;
      s2_v_q <= s1_v_q;
      // close the bucket
      if (state_q == S_LDWAIT) begin
        prev_idx_q  <= best_q;
        prev_val_q  <= rdata_q;
        bucket_q    <= bucket_q + 1'b1;
        vsum_q      <= '0;
        isum_q      <= '0;
        cnt_q       <= '0;
        bnd_valid_q <= 1'b0;
        res_cnt_q   <= item_last_q ? 2'd2 : 2'd1;
      end
      // output register
      if (out_load) begin
        out_valid_q <= 1'b1;
        res_ptr_q   <= res_ptr_q + 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
      // end of run
      if (state_q == S_EMIT && res_ptr_q == res_cnt_q && item_last_q) begin
        bucket_q    <= '0;
        prev_idx_q  <= '0;
        prev_val_q  <= '0;
        vsum_q      <= '0;
        isum_q      <= '0;
        cnt_q       <= '0;
        bnd_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_i_q <= i_cur[AddrW-1:0];
      item_v_q <= in_if.sample_value;
    end
    // result slot contents
    if (state_q == S_PLAN) begin
      if (t_v >= n_c) begin
        res_idx_q[0]  <= item_i_q;
        res_done_q[0] <= item_last_q;
      end else if (item_i_q == '0) begin
        res_idx_q[0]  <= '0;
        res_done_q[0] <= 1'b0;
        res_idx_q[1]  <= n_m1[AddrW-1:0];
        res_done_q[1] <= 1'b1;
      end else begin
        res_idx_q[0]  <= n_m1[AddrW-1:0];
        res_done_q[0] <= 1'b1;
      end
    end
    if (state_q == S_LDWAIT) begin
      res_idx_q[0]  <= best_q;
      res_done_q[0] <= 1'b0;
      res_idx_q[1]  <= n_m1[AddrW-1:0];
      res_done_q[1] <= 1'b1;
    end
    if (state_q == S_DIVWAIT && div_done) bnd_q[bi_q] <= BndW'(div_q) + 1'b1;
    // selection setup
    if (state_q == S_SELPREP) begin
      pc_q        <= PcW'(prev_idx_q) * PcW'(cnt_q);
      ypc_q       <= DyW'(prev_val_q) * DyW'($signed({1'b0, cnt_q}));
      j_q         <= bnd_q[0][CntW-1:0];
      best_q      <= bnd_q[0][AddrW-1:0];
      best_area_q <= '1;
      be_q        <= be_v;
    end
    if (state_q == S_SELDXDY) begin
      dx_q <= $signed({2'b0, pc_q}) - $signed({2'b0, isum_q});
      dy_q <= DyW'(vsum_q) - ypc_q;
    end
    // scan stages
    if (issue) j_q <= j_q + 1'b1;
    s1_j_q <= j_q[AddrW-1:0];
    s2_j_q <= s1_j_q;
    pa_q   <= pa_d;
    pb_q   <= pb_d;
    if (s2_v_q && area_abs > best_area_q) begin
      best_area_q <= area_abs;
      best_q      <= s2_j_q;
    end
    if (out_load) begin
      out_idx_q  <= res_idx_q[res_ptr_q[0]];
      out_done_q <= res_done_q[res_ptr_q[0]];
      out_last_q <= (res_ptr_q + 1'b1) == res_cnt_q;
    end
  end

  assign in_if.ready           = (state_q == S_IDLE);
  assign out_if.valid          = out_valid_q;
  assign out_if.kept_index     = out_idx_q;
  assign out_if.run_last       = out_last_q;
  assign out_if.selection_done = out_done_q;

endmodule

`default_nettype wire

/* design/lttb_div.sv */
// ----------------------------------------------------------------------------
// lttb_div
// Restoring divider, one quotient bit per cycle, used for bucket bounds.
// ----------------------------------------------------------------------------
`default_nettype none

module lttb_div (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start_i,
  input  wire  [lttb_pkg::DivNW-1:0]   dividend_i,
  input  wire  [lttb_pkg::DivDW-1:0]   divisor_i,
  output logic                         done_o,
  output logic [lttb_pkg::DivNW-1:0]   quotient_o
);
  import lttb_pkg::*;

  localparam int StepW = $clog2(DivNW + 1);

  logic [DivDW-1:0] rem_q;
  logic [DivNW-1:0] quo_q;
  logic [DivDW-1:0] dvs_q;
  logic [StepW-1:0] step_q;
  logic             busy_q;
  logic             done_q;
  logic [DivDW:0]   trial;
  logic             fits;

  // trial subtract of the shifted remainder
  assign trial = {rem_q, quo_q[DivNW-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == StepW'(DivNW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? DivDW'(trial - {1'b0, dvs_q}) : trial[DivDW-1:0];
      quo_q <= {quo_q[DivNW-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire
